FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked concurrent assertions that report through $error
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: hdl/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Register map and result codes of the wildcard byte signature scanner
// ----------------------------------------------------------------------------
package wbss_pkg;

   localparam int CsrAddrBits = 6;
   localparam int CsrDataBits = 64;

   typedef enum logic [2:0] {
      REG_PATTERN_LO     = 3'd0,
      REG_PATTERN_MID_LO = 3'd1,
      REG_PATTERN_MID_HI = 3'd2,
      REG_PATTERN_HI     = 3'd3,
      REG_CARE_MASK      = 3'd4,
      REG_PATTERN_LENGTH = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      UNIQ_NONE    = 2'd0,
      UNIQ_ONE     = 2'd1,
      UNIQ_SEVERAL = 2'd2
   } uniqueness_type;

   localparam logic [5:0] PatternLengthReset = 6'd1;

endpackage

FILE: hdl/wildcard_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner
// Masked byte pattern matcher over a streamed memory range
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one byte per transfer, with first_of_range / last_of_range
//   marks. rsp channel: one result for a byte that ends a match (hit, start
//   offset) and for the last byte of a range (range_done, uniqueness).
//   Bytes that neither hit nor end a range give no result.
//   Pattern, care mask and length are to be written over the APB port while
//   idle (not enforced by the block); a write takes effect for the next byte.
// Pipeline:
//   A byte is registered into the first stage when it is taken, and its
//   result is registered onto the rsp ports by the second. One byte is taken
//   every cycle while req_stall is low: the window shift and alignment sit in
//   the first register stage, the 32-lane masked compare and the skip/tally
//   update in the second.
// Reset:
//   Synchronous. Clears the window, position, skip and tally, the pattern
//   registers and mask to zero, and pattern_length to one.
// Stall:
//   While rsp_stall holds a result, one more byte may be taken into the
//   first stage; after that req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner
   import wbss_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int OFFSET_BITS       = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_of_range,
   input  logic                   req_last_of_range,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [31:0]            rsp_hit_offset,
   output logic                   rsp_range_done,
   output logic [1:0]             rsp_uniqueness,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [CsrDataBits-1:0] pwdata,
   output logic [CsrDataBits-1:0] prdata,
   output logic                   pready
);

   localparam int         WinBits = 8 * MAX_PATTERN_BYTES;
   localparam logic [5:0] MaxLen  = 6'(MAX_PATTERN_BYTES);

   // configuration registers
   logic [63:0] pat_lo_ff, pat_lo_in;
   logic [63:0] pat_ml_ff, pat_ml_in;
   logic [63:0] pat_mh_ff, pat_mh_in;
   logic [63:0] pat_hi_ff, pat_hi_in;
   logic [31:0] care_ff, care_in;
   logic [5:0]  plen_ff, plen_in;

   // stage 1: window and aligned copy
   logic [WinBits-1:0]     win_ff, win_in;
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [WinBits-1:0]     s1_align_ff, s1_align_in;
   logic                   s1_full_ff, s1_full_in;
   logic [OFFSET_BITS-1:0] s1_off_ff, s1_off_in;
   logic                   s1_first_ff, s1_first_in;
   logic                   s1_last_ff, s1_last_in;

   // stage 2: match state and result register
   logic [5:0]  skip_ff, skip_in;
   logic [1:0]  tally_ff, tally_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [31:0] rsp_off_ff, rsp_off_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [1:0]  rsp_uniq_ff, rsp_uniq_in;

   logic                       csr_write;
   csr_index_type              csr_index;
   logic [5:0]                 len_eff;
   logic [5:0]                 len_m1;
   logic [8:0]                 align_shift;
   logic                       out_load;
   logic                       s1_advance;
   logic                       req_accept;
   logic [OFFSET_BITS-1:0]     pos;
   logic [WinBits-1:0]         win_rev;
   logic [255:0]               pat_all;
   logic [MAX_PATTERN_BYTES-1:0] care_eff;
   logic                       window_match;
   logic [5:0]                 skip_cur;
   logic [1:0]                 tally_cur;
   logic                       hit_now;

   assign csr_write = psel & penable & pwrite;
   assign csr_index = csr_index_type'(paddr[5:3]);
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         REG_PATTERN_LO:     prdata = pat_lo_ff;
         REG_PATTERN_MID_LO: prdata = pat_ml_ff;
         REG_PATTERN_MID_HI: prdata = pat_mh_ff;
         REG_PATTERN_HI:     prdata = pat_hi_ff;
         REG_CARE_MASK:      prdata = {32'd0, care_ff};
         REG_PATTERN_LENGTH: prdata = {58'd0, plen_ff};
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_ml_in = pat_ml_ff;
      pat_mh_in = pat_mh_ff;
      pat_hi_in = pat_hi_ff;
      care_in   = care_ff;
      plen_in   = plen_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LO:     pat_lo_in = pwdata;
            REG_PATTERN_MID_LO: pat_ml_in = pwdata;
            REG_PATTERN_MID_HI: pat_mh_in = pwdata;
            REG_PATTERN_HI:     pat_hi_in = pwdata;
            REG_CARE_MASK:      care_in   = pwdata[31:0];
            REG_PATTERN_LENGTH: plen_in   = pwdata[5:0];
            default:            ;
         endcase
      end
   end

   // clamp length into 1..MAX_PATTERN_BYTES
   always_comb begin
      if (plen_ff == 6'd0) begin
         len_eff = 6'd1;
      end else if (plen_ff > MaxLen) begin
         len_eff = MaxLen;
      end else begin
         len_eff = plen_ff;
      end
   end

   assign len_m1      = len_eff - 6'd1;
   assign align_shift = {MaxLen - len_eff, 3'b000};

   // handshake
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_load;
   assign req_stall  = s1_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   // stage 1: shift the byte in and align the window to the pattern
   always_comb begin
      pos     = req_first_of_range ? '0 : seen_ff;
      win_in  = win_ff;
      seen_in = seen_ff;
      if (req_accept) begin
         win_in  = WinBits'({win_ff, req_data_byte});
         seen_in = req_last_of_range ? '0 : pos + OFFSET_BITS'(1);
      end
      // reverse byte order so the oldest byte of the pattern span lands at lane 0
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         win_rev[8*k +: 8] = win_in[8*(MAX_PATTERN_BYTES-1-k) +: 8];
      end
      s1_align_in = win_rev >> align_shift;
      s1_full_in  = pos >= OFFSET_BITS'(len_m1);
      s1_off_in   = pos - OFFSET_BITS'(len_m1);
      s1_first_in = req_first_of_range;
      s1_last_in  = req_last_of_range;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // stage 2: masked compare
   assign pat_all = {pat_hi_ff, pat_mh_ff, pat_ml_ff, pat_lo_ff};

   always_comb begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         care_eff[i] = care_ff[i] && (6'(i) < len_eff);
      end
      window_match = |care_eff;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (care_eff[i] && (s1_align_ff[8*i +: 8] != pat_all[8*i +: 8])) begin
            window_match = 1'b0;
         end
      end
   end

   // stage 2: skip, tally and result
   always_comb begin
      skip_cur     = s1_first_ff ? 6'd0 : skip_ff;
      tally_cur    = s1_first_ff ? 2'd0 : tally_ff;
      hit_now      = 1'b0;
      skip_in      = skip_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_uniq_in  = rsp_uniq_ff;
      if (s1_advance) begin
         skip_in  = skip_cur;
         tally_in = tally_cur;
         if (skip_cur != 6'd0) begin
            skip_in = skip_cur - 6'd1;
         end else if (s1_full_ff && window_match) begin
            hit_now  = 1'b1;
            skip_in  = len_m1;
            tally_in = (tally_cur == UNIQ_SEVERAL) ? UNIQ_SEVERAL : tally_cur + 2'd1;
         end
         rsp_hit_in  = hit_now;
         rsp_off_in  = hit_now ? 32'(s1_off_ff) : 32'd0;
         rsp_done_in = s1_last_ff;
         rsp_uniq_in = s1_last_ff ? tally_in : UNIQ_NONE;
         // a range end drops position-dependent state
         if (s1_last_ff) begin
            skip_in  = 6'd0;
            tally_in = 2'd0;
         end
      end
      if (out_load) begin
         rsp_valid_in = s1_advance && (hit_now || s1_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff    <= '0;
         pat_ml_ff    <= '0;
         pat_mh_ff    <= '0;
         pat_hi_ff    <= '0;
         care_ff      <= '0;
         plen_ff      <= PatternLengthReset;
         win_ff       <= '0;
         seen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         skip_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_lo_ff    <= pat_lo_in;
         pat_ml_ff    <= pat_ml_in;
         pat_mh_ff    <= pat_mh_in;
         pat_hi_ff    <= pat_hi_in;
         care_ff      <= care_in;
         plen_ff      <= plen_in;
         win_ff       <= win_in;
         seen_ff      <= seen_in;
         s1_valid_ff  <= s1_valid_in;
         skip_ff      <= skip_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_align_ff <= s1_align_in;
         s1_full_ff  <= s1_full_in;
         s1_off_ff   <= s1_off_in;
         s1_first_ff <= s1_first_in;
         s1_last_ff  <= s1_last_in;
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_done_ff <= rsp_done_in;
      rsp_uniq_ff <= rsp_uniq_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_offset = rsp_off_ff;
   assign rsp_range_done = rsp_done_ff;
   assign rsp_uniqueness = rsp_uniq_ff;

endmodule

FILE: hdl/wbss_checker.sv
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks of the scanner's result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbss_checker
   import wbss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_hit_offset,
   input logic        rsp_range_done,
   input logic [1:0]  rsp_uniqueness
);

   // every result carries a hit or a range end
   `ASSERT_CLK(a_no_empty_result, clock, reset, rsp_valid |-> (rsp_hit || rsp_range_done), "result with neither hit nor range end")

   // status shows only on the range's last result
   `ASSERT_CLK(a_uniq_only_at_end, clock, reset, (rsp_valid && !rsp_range_done) |-> (rsp_uniqueness == UNIQ_NONE), "uniqueness set before range end")

   // a hit on the last byte is counted in that status
   `ASSERT_CLK(a_hit_counted, clock, reset, (rsp_valid && rsp_range_done && rsp_hit) |-> (rsp_uniqueness == UNIQ_ONE || rsp_uniqueness == UNIQ_SEVERAL), "hit on last byte not counted")

   // offset is zero unless the result is a hit
   `ASSERT_CLK(a_offset_zero, clock, reset, (rsp_valid && !rsp_hit) |-> (rsp_hit_offset == 32'd0), "offset without hit")

   // a stalled result holds
   `ASSERT_CLK(a_stall_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit_offset) && $stable(rsp_uniqueness)), "stalled result changed")

endmodule

bind wildcard_byte_signature_scanner wbss_checker u_wbss_checker (.*);

FILE: verif/wildcard_byte_signature_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner_test
// Self-checking bench for the masked byte pattern scanner. A short directed
// table covers the register defaults, one-byte and wildcard patterns,
// non-overlapping hits, clamped lengths and masks with no literal byte.
// Random phases follow: each one reprograms the pattern, mask and length,
// then streams ranges built mostly from embedded (and sometimes truncated)
// pattern copies. Every result transfer is compared field by field with a
// cycle-free predictor of the scanner, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_test;
   import wbss_pkg::*;

   localparam int MaxPatternBytes = 32;
   localparam int PipeSettle      = 8;
   localparam int PhaseCount      = 10;
   localparam int PhaseBytes      = 66;
   localparam int DrainLimit      = 20000;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_TYPED
   } chk_kind_type;

   typedef struct {
      logic           hit;
      logic [31:0]    offset;
      logic           done;
      uniqueness_type uniq;
   } scan_result_type;

   typedef struct {
      bit              is_cfg;
      csr_index_type   idx;
      logic [63:0]     value;
      logic [7:0]      data;
      bit              first;
      bit              last;
      chk_kind_type    chk;
      scan_result_type want;
   } stim_row_type;

   logic                   clock;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte      = '0;
   logic                   req_first_of_range = 1'b0;
   logic                   req_last_of_range  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_hit;
   logic [31:0]            rsp_hit_offset;
   logic                   rsp_range_done;
   logic [1:0]             rsp_uniqueness;
   logic                   psel               = 1'b0;
   logic                   penable            = 1'b0;
   logic                   pwrite             = 1'b0;
   logic [CsrAddrBits-1:0] paddr              = '0;
   logic [CsrDataBits-1:0] pwdata             = '0;
   logic [CsrDataBits-1:0] prdata;
   logic                   pready;

   // shadow configuration and scan state
   logic [63:0] pat_word [4]        = '{default: '0};
   logic [31:0] care_bits           = '0;
   logic [5:0]  len_reg             = PatternLengthReset;
   logic [7:0]  shadow_window [32]  = '{default: '0};
   logic [31:0] seen_count          = '0;
   logic [5:0]  skip_count          = '0;
   logic [1:0]  tally_count         = '0;

   scan_result_type expect_q [$];
   stim_row_type    directed_q [$];

   int unsigned error_count    = 0;
   int unsigned bytes_sent     = 0;
   int unsigned results_seen   = 0;
   int unsigned hits_seen      = 0;
   int unsigned ranges_closed  = 0;
   int unsigned send_gap_pct   = 20;
   int unsigned stall_pct      = 20;
   int unsigned stall_left     = 0;
   bit          req_live       = 1'b0;

   wildcard_byte_signature_scanner dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_of_range (req_first_of_range),
      .req_last_of_range  (req_last_of_range),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_hit_offset     (rsp_hit_offset),
      .rsp_range_done     (rsp_range_done),
      .rsp_uniqueness     (rsp_uniqueness),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("run did not finish in time");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic scan_result_type mk_result(logic hit, logic [31:0] off, logic done,
                                                 uniqueness_type u);
      scan_result_type r;
      r.hit    = hit;
      r.offset = off;
      r.done   = done;
      r.uniq   = u;
      return r;
   endfunction

   function automatic int unsigned active_length();
      int unsigned n;
      n = 32'(len_reg);
      if (n == 0) n = 1;
      if (n > MaxPatternBytes) n = MaxPatternBytes;
      return n;
   endfunction

   function automatic logic [7:0] pattern_at(int unsigned i);
      return pat_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
   endfunction

   function automatic bit window_hit(int unsigned n);
      logic [31:0] span;
      span = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
      if ((care_bits & span) == 0) return 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
         if (care_bits[i] && shadow_window[n - 1 - i] != pattern_at(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // advance the shadow state by one byte; returns 1 when a result is due
   function automatic bit scan_step(input logic [7:0] d, input bit first, input bit last,
                                    output scan_result_type r);
      int unsigned n;
      logic [31:0] pos;
      bit          matched;
      n       = active_length();
      matched = 1'b0;
      r       = mk_result(1'b0, '0, 1'b0, UNIQ_NONE);
      if (first) begin
         seen_count  = '0;
         skip_count  = '0;
         tally_count = '0;
      end
      for (int k = 31; k > 0; k--) shadow_window[k] = shadow_window[k - 1];
      shadow_window[0] = d;
      pos = seen_count;
      if (skip_count != 0) begin
         skip_count = skip_count - 6'd1;
      end else if (pos >= n - 1 && window_hit(n)) begin
         matched    = 1'b1;
         r.hit      = 1'b1;
         r.offset   = pos - (n - 1);
         skip_count = 6'(n - 1);
         if (tally_count < 2) tally_count = tally_count + 2'd1;
      end
      seen_count = seen_count + 32'd1;
      if (!matched && !last) return 1'b0;
      if (last) begin
         r.done      = 1'b1;
         r.uniq      = uniqueness_type'(tally_count);
         seen_count  = '0;
         skip_count  = '0;
         tally_count = '0;
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // drop valid once after the last transfer
   task automatic drop_valid();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live  = 1'b0;
      end
   endtask

   task automatic drain_results();
      if (expect_q.size() != 0) begin
         drop_valid();
         while (expect_q.size() != 0) @(posedge clock);
      end
   endtask

   // let the pipeline empty out, since plain bytes leave nothing to wait on
   task automatic settle();
      drain_results();
      drop_valid();
      repeat (PipeSettle) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PATTERN_LO, REG_PATTERN_MID_LO,
         REG_PATTERN_MID_HI, REG_PATTERN_HI: pat_word[idx] = value;
         REG_CARE_MASK:                      care_bits = value[31:0];
         REG_PATTERN_LENGTH:                 len_reg = value[5:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] d, input bit first, input bit last,
                            input chk_kind_type chk, input scan_result_type typed);
      scan_result_type predicted;
      bit              produced;
      req_valid          <= 1'b1;
      req_data_byte      <= d;
      req_first_of_range <= first;
      req_last_of_range  <= last;
      req_live           = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      produced = scan_step(d, first, last, predicted);
      case (chk)
         CHK_MODEL: if (produced) expect_q.insert(expect_q.size(), predicted);
         CHK_TYPED: expect_q.insert(expect_q.size(), typed);
         default: ;
      endcase
      bytes_sent++;
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         drop_valid();
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // one range: mostly pattern copies with random wildcard bytes, some cut short
   task automatic run_range();
      logic [7:0]      buf_q [$];
      int unsigned     target;
      int unsigned     n;
      int unsigned     cut;
      bit              first_flag;
      bit              last_flag;
      scan_result_type blank;
      blank  = mk_result(1'b0, '0, 1'b0, UNIQ_NONE);
      target = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      n      = active_length();
      while (buf_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;
               for (int unsigned i = 0; i < cut; i++)
                  buf_q.insert(buf_q.size(), care_bits[i] ? pattern_at(i) : 8'($urandom));
            end
            5, 6, 7: buf_q.insert(buf_q.size(), 8'($urandom));
            default: buf_q.insert(buf_q.size(), pattern_at($urandom_range(0, n - 1)));
         endcase
      end
      foreach (buf_q[i]) begin
         first_flag = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 59) == 0);
         last_flag  = (i == buf_q.size() - 1) && ($urandom_range(0, 15) != 0);
         push_byte(buf_q[i], first_flag, last_flag, CHK_MODEL, blank);
      end
   endtask

   // ------------------------------------------------------------------
   // result side: random back-pressure and the scoreboard
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= pick_gap() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      scan_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expect_q.size() == 0) begin
            report_mismatch("result with nothing expected, offset", rsp_hit_offset, '0);
         end else begin
            want = expect_q.pop_front();
            results_seen++;
            if (want.hit) hits_seen++;
            if (want.done) ranges_closed++;
            if (rsp_hit !== want.hit)
               report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
            if (rsp_hit_offset !== want.offset)
               report_mismatch("hit_offset", rsp_hit_offset, want.offset);
            if (rsp_range_done !== want.done)
               report_mismatch("range_done", 32'(rsp_range_done), 32'(want.done));
            if (rsp_uniqueness !== want.uniq)
               report_mismatch("uniqueness", 32'(rsp_uniqueness), 32'(want.uniq));
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic stim_row_type byte_row(logic [7:0] d, bit first, bit last,
                                             chk_kind_type chk, scan_result_type want);
      stim_row_type r;
      r.is_cfg = 1'b0;
      r.idx    = REG_PATTERN_LO;
      r.value  = '0;
      r.data   = d;
      r.first  = first;
      r.last   = last;
      r.chk    = chk;
      r.want   = want;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(csr_index_type idx, logic [63:0] value);
      stim_row_type r;
      r        = byte_row('0, 1'b0, 1'b0, CHK_NONE, mk_result(1'b0, '0, 1'b0, UNIQ_NONE));
      r.is_cfg = 1'b1;
      r.idx    = idx;
      r.value  = value;
      return r;
   endfunction

   task automatic add_row(input stim_row_type row);
      directed_q.insert(directed_q.size(), row);
   endtask

   initial begin
      scan_result_type nil;
      int unsigned     phase_start;
      int unsigned     plen;
      logic [63:0]     pats [4];
      logic [31:0]     care;
      int unsigned     waited;

      nil = mk_result(1'b0, '0, 1'b0, UNIQ_NONE);

      // defaults: empty mask, so nothing can hit
      add_row(byte_row(8'hFF, 1, 0, CHK_NONE, nil));
      add_row(byte_row(8'h00, 0, 1, CHK_TYPED, mk_result(0, 0, 1, UNIQ_NONE)));
      // one literal byte
      add_row(cfg_row(REG_PATTERN_LO, 64'hA5));
      add_row(cfg_row(REG_CARE_MASK, 64'h1));
      add_row(byte_row(8'hA5, 1, 0, CHK_TYPED, mk_result(1, 0, 0, UNIQ_NONE)));
      add_row(byte_row(8'h00, 0, 0, CHK_NONE, nil));
      add_row(byte_row(8'hA5, 0, 1, CHK_TYPED, mk_result(1, 2, 1, UNIQ_SEVERAL)));
      // new range starts after a last byte even without a first mark
      add_row(byte_row(8'hA5, 0, 1, CHK_TYPED, mk_result(1, 0, 1, UNIQ_ONE)));
      // zero length behaves as one
      add_row(cfg_row(REG_PATTERN_LENGTH, 64'd0));
      add_row(byte_row(8'hFF, 1, 1, CHK_TYPED, mk_result(0, 0, 1, UNIQ_NONE)));
      // three bytes, middle one wildcard, mask bits above the length set
      add_row(cfg_row(REG_PATTERN_LENGTH, 64'd3));
      add_row(cfg_row(REG_PATTERN_LO, 64'h3C_00A5));
      add_row(cfg_row(REG_CARE_MASK, 64'hFFFF_FF05));
      add_row(byte_row(8'hA5, 1, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h77, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h3C, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'hA5, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h00, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h3C, 0, 0, CHK_MODEL, nil));
      // overlapping candidate right after a hit must be skipped
      add_row(byte_row(8'hA5, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'hA5, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h3C, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h3C, 0, 0, CHK_MODEL, nil));
      add_row(byte_row(8'h00, 0, 1, CHK_MODEL, nil));
      // literals only above the length: never matches
      add_row(cfg_row(REG_CARE_MASK, 64'hFFFF_FFF8));
      add_row(byte_row(8'hA5, 1, 0, CHK_NONE, nil));
      add_row(byte_row(8'h00, 0, 0, CHK_NONE, nil));
      add_row(byte_row(8'h3C, 0, 1, CHK_TYPED, mk_result(0, 0, 1, UNIQ_NONE)));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[k]) begin
         if (directed_q[k].is_cfg) begin
            settle();
            write_csr(directed_q[k].idx, directed_q[k].value);
         end else begin
            push_byte(directed_q[k].data, directed_q[k].first, directed_q[k].last,
                      directed_q[k].chk, directed_q[k].want);
         end
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         foreach (pats[w]) pats[w] = {$urandom, $urandom};
         case ($urandom_range(0, 2))
            0:       care = $urandom | $urandom;
            1:       care = $urandom & $urandom;
            default: care = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0:       plen = $urandom_range(32, 63);
            1, 2:    plen = $urandom_range(9, 31);
            default: plen = $urandom_range(1, 8);
         endcase
         case (phase)
            0: begin
               foreach (pats[w]) pats[w] = '1;
               care = '1;
               plen = 32;
            end
            1: plen = 1;
            2: begin
               foreach (pats[w]) pats[w] = '0;
               care = care | 32'h1;
               plen = 0;
            end
            3: plen = 63;
            4: care = '0;
            default: ;
         endcase

         settle();
         write_csr(REG_PATTERN_LO, pats[0]);
         write_csr(REG_PATTERN_MID_LO, pats[1]);
         write_csr(REG_PATTERN_MID_HI, pats[2]);
         write_csr(REG_PATTERN_HI, pats[3]);
         write_csr(REG_CARE_MASK, {32'h0, care});
         write_csr(REG_PATTERN_LENGTH, 64'(plen));

         send_gap_pct = (phase % 3 == 0) ? 0 : 30;
         stall_pct    = (phase % 4 == 1) ? 0 : ((phase == 6) ? 60 : 25);

         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            run_range();
            // hold the sender until everything outstanding has come back
            if ($urandom_range(0, 19) == 0) drain_results();
         end
      end

      drop_valid();
      waited = 0;
      while (waited < DrainLimit && expect_q.size() != 0) begin
         @(posedge clock);
         waited++;
      end
      repeat (PipeSettle) @(posedge clock);
      if (expect_q.size() != 0)
         report_mismatch("results never delivered, count", 32'(expect_q.size()), '0);

      $display("streamed %0d bytes over %0d register settings plus the directed table",
               bytes_sent, PhaseCount);
      $display("compared %0d results: %0d hits, %0d range closes, %0d mismatches",
               results_seen, hits_seen, ranges_closed, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
